[rtl/ilpp_pkg.sv]
// ---------------------------------------------------------------------------
// ilpp_pkg
// Types and constants shared by the IPv6 literal and port parser.
// ---------------------------------------------------------------------------
package ilpp_pkg;

    localparam int GROUPS      = 8;
    localparam int GROUP_W     = 16;
    localparam int ADDR_W      = GROUPS * GROUP_W;
    localparam int HALF_W      = ADDR_W / 2;
    localparam int PORT_W      = 27;
    localparam int PLEN_W      = 4;
    localparam int COUNT_W     = 4;
    localparam int DIGITS_W    = 3;

    // longest port text that still counts as a port
    localparam logic [PLEN_W-1:0] PORT_TEXT_MAX = 4'd8;
    localparam logic [PLEN_W-1:0] PLEN_SAT      = 4'd15;
    localparam logic [COUNT_W-1:0] GROUPS_FULL  = 4'd8;
    localparam logic [DIGITS_W-1:0] GROUP_DIGITS = 3'd4;

    localparam logic [7:0] CH_OPEN   = 8'h5B;
    localparam logic [7:0] CH_CLOSE  = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;

    typedef enum logic [2:0] {
        PH_WAIT = 3'd0,
        PH_ADDR = 3'd1,
        PH_SKIP = 3'd2,
        PH_PORT = 3'd3,
        PH_DONE = 3'd4
    } phase_t;

    // one classified character
    typedef struct packed {
        logic       hex_ok;
        logic       is_digit;
        logic [3:0] nibble;
        logic       is_colon;
        logic       is_open;
        logic       is_close;
        logic       is_slash;
        logic       last;
    } item_t;

endpackage

[rtl/ilpp_front.sv]
// ---------------------------------------------------------------------------
// ilpp_front
// Classifies each incoming character into digit, hex and delimiter flags.
// ---------------------------------------------------------------------------
module ilpp_front (
    input  logic [7:0]     char_code,
    input  logic           last_char,
    output ilpp_pkg::item_t item
);

    logic is_dec;
    logic is_alpha;

    always_comb
    begin
        is_dec   = char_code inside {[ilpp_pkg::CH_0:ilpp_pkg::CH_9]};
        is_alpha = char_code inside {[ilpp_pkg::CH_LA:ilpp_pkg::CH_LF],
                                     [ilpp_pkg::CH_UA:ilpp_pkg::CH_UF]};

        item.hex_ok   = is_dec | is_alpha;
        item.is_digit = is_dec;
        // letters a..f / A..F have low nibble 1..6
        item.nibble   = is_alpha ? (char_code[3:0] + 4'd9) : char_code[3:0];
        item.is_colon = (char_code == ilpp_pkg::CH_COLON);
        item.is_open  = (char_code == ilpp_pkg::CH_OPEN);
        item.is_close = (char_code == ilpp_pkg::CH_CLOSE);
        item.is_slash = (char_code == ilpp_pkg::CH_SLASH);
        item.last     = last_char;
    end

endmodule

[rtl/ilpp_queue.sv]
// ---------------------------------------------------------------------------
// ilpp_queue
// Two-entry queue between the classifier and the parser.
// ---------------------------------------------------------------------------
module ilpp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ilpp_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            avail,
    output ilpp_pkg::item_t head
);

    ilpp_pkg::item_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign full  = (count_reg == 2'd2);
    assign avail = (count_reg != 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        do_push     = push & ~full;
        do_pop      = pop & avail;
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/ilpp_back.sv]
// ---------------------------------------------------------------------------
// ilpp_back
// Parse sequencer: address groups, gap, port digits, and the result register.
// ---------------------------------------------------------------------------
module ilpp_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         avail,
    input  ilpp_pkg::item_t              head,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [ilpp_pkg::HALF_W-1:0]  addr_high,
    output logic [ilpp_pkg::HALF_W-1:0]  addr_low,
    output logic                         addr_error,
    output logic [ilpp_pkg::PORT_W-1:0]  port_value,
    output logic                         port_found
);

    // groups before the gap sit at their final slot; groups after it shift in
    // from the bottom, so the two never overlap and the address is their OR
    logic [ilpp_pkg::GROUP_W-1:0]  pre_reg  [ilpp_pkg::GROUPS];
    logic [ilpp_pkg::GROUP_W-1:0]  pre_next [ilpp_pkg::GROUPS];
    logic [ilpp_pkg::ADDR_W-1:0]   post_reg, post_next;
    logic [ilpp_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic [ilpp_pkg::GROUP_W-1:0]  accum_reg, accum_next;
    logic [ilpp_pkg::DIGITS_W-1:0] digits_reg, digits_next;
    logic [ilpp_pkg::COUNT_W-1:0]  gap_pos_reg, gap_pos_next;
    logic                          gap_reg, gap_next;
    ilpp_pkg::phase_t              phase_reg, phase_next;
    logic [ilpp_pkg::PORT_W-1:0]   port_reg, port_next;
    logic [ilpp_pkg::PLEN_W-1:0]   plen_reg, plen_next;
    logic                          pdone_reg, pdone_next;
    logic                          err_reg, err_next;
    logic                          colon_reg, colon_next;

    logic                          ovalid_reg, ovalid_next;
    logic [ilpp_pkg::HALF_W-1:0]   hi_reg, hi_next;
    logic [ilpp_pkg::HALF_W-1:0]   lo_reg, lo_next;
    logic                          bad_reg, bad_next;
    logic [ilpp_pkg::PORT_W-1:0]   pval_reg, pval_next;
    logic                          found_reg, found_next;

    logic                          do_commit;
    logic                          check_close;
    logic                          finish;
    logic                          bad;
    logic                          found;
    logic [ilpp_pkg::ADDR_W-1:0]   addr_flat;

    assign out_valid  = ovalid_reg;
    assign addr_high  = hi_reg;
    assign addr_low   = lo_reg;
    assign addr_error = bad_reg;
    assign port_value = pval_reg;
    assign port_found = found_reg;

    // a last character needs the result slot free (or freeing this cycle)
    assign pop    = avail & (~head.last | ~ovalid_reg | ~out_stall);
    assign finish = pop & head.last;

    always_comb
    begin
        pre_next     = pre_reg;
        post_next    = post_reg;
        count_next   = count_reg;
        accum_next   = accum_reg;
        digits_next  = digits_reg;
        gap_pos_next = gap_pos_reg;
        gap_next     = gap_reg;
        phase_next   = phase_reg;
        port_next    = port_reg;
        plen_next    = plen_reg;
        pdone_next   = pdone_reg;
        err_next     = err_reg;
        colon_next   = colon_reg;
        do_commit    = 1'b0;
        check_close  = 1'b0;

        if (pop)
        begin
            case (phase_reg)
                ilpp_pkg::PH_WAIT:
                begin
                    if (head.is_open)
                    begin
                        phase_next = ilpp_pkg::PH_ADDR;
                    end
                end
                ilpp_pkg::PH_ADDR:
                begin
                    if (head.is_close)
                    begin
                        phase_next = ilpp_pkg::PH_SKIP;
                        if (!err_reg)
                        begin
                            check_close = 1'b1;
                            if (digits_reg != '0)
                            begin
                                do_commit = 1'b1;
                            end
                            else if (!(colon_reg && gap_reg && gap_pos_reg == count_reg))
                            begin
                                err_next = 1'b1;
                            end
                        end
                    end
                    else if (!err_reg)
                    begin
                        if (head.hex_ok)
                        begin
                            if (colon_reg && count_reg == '0 && !gap_reg)
                            begin
                                err_next = 1'b1;
                            end
                            else if (digits_reg >= ilpp_pkg::GROUP_DIGITS)
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                accum_next  = {accum_reg[ilpp_pkg::GROUP_W-5:0], head.nibble};
                                digits_next = digits_reg + 3'd1;
                                colon_next  = 1'b0;
                            end
                        end
                        else if (head.is_colon)
                        begin
                            if (colon_reg)
                            begin
                                if (gap_reg)
                                begin
                                    err_next = 1'b1;
                                end
                                else
                                begin
                                    gap_next     = 1'b1;
                                    gap_pos_next = count_reg;
                                end
                            end
                            else if (digits_reg == '0)
                            begin
                                // lone leading colon is fine only as start of a gap
                                if (count_reg == '0 && !gap_reg)
                                begin
                                    colon_next = 1'b1;
                                end
                                else
                                begin
                                    err_next = 1'b1;
                                end
                            end
                            else
                            begin
                                do_commit  = 1'b1;
                                colon_next = 1'b1;
                            end
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                    end
                end
                ilpp_pkg::PH_SKIP:
                begin
                    phase_next = ilpp_pkg::PH_PORT;
                end
                ilpp_pkg::PH_PORT:
                begin
                    if (head.is_slash)
                    begin
                        phase_next = ilpp_pkg::PH_DONE;
                    end
                    else
                    begin
                        if (plen_reg != ilpp_pkg::PLEN_SAT)
                        begin
                            plen_next = plen_reg + 4'd1;
                        end
                        if (!pdone_reg)
                        begin
                            if (head.is_digit)
                            begin
                                // x*10 = x*8 + x*2, wraps at the port width
                                port_next = {port_reg[ilpp_pkg::PORT_W-4:0], 3'b000}
                                          + {port_reg[ilpp_pkg::PORT_W-2:0], 1'b0}
                                          + {{(ilpp_pkg::PORT_W-4){1'b0}}, head.nibble};
                            end
                            else
                            begin
                                pdone_next = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (do_commit)
        begin
            if (count_reg >= ilpp_pkg::GROUPS_FULL)
            begin
                err_next = 1'b1;
            end
            else
            begin
                if (!gap_reg)
                begin
                    pre_next[count_reg[2:0]] = accum_reg;
                end
                else
                begin
                    post_next = {post_reg[ilpp_pkg::ADDR_W-ilpp_pkg::GROUP_W-1:0], accum_reg};
                end
                count_next  = count_reg + 4'd1;
                accum_next  = '0;
                digits_next = '0;
            end
        end

        if (check_close)
        begin
            if (gap_next ? (count_next >= ilpp_pkg::GROUPS_FULL)
                         : (count_next != ilpp_pkg::GROUPS_FULL))
            begin
                err_next = 1'b1;
            end
        end

        bad   = err_next || phase_next == ilpp_pkg::PH_WAIT || phase_next == ilpp_pkg::PH_ADDR;
        found = (phase_next == ilpp_pkg::PH_DONE) && (plen_next <= ilpp_pkg::PORT_TEXT_MAX);

        for (int k = 0; k < ilpp_pkg::GROUPS; k++)
        begin
            addr_flat[ilpp_pkg::ADDR_W-1-k*ilpp_pkg::GROUP_W -: ilpp_pkg::GROUP_W] = pre_next[k];
        end
        addr_flat = addr_flat | post_next;

        hi_next    = hi_reg;
        lo_next    = lo_reg;
        bad_next   = bad_reg;
        pval_next  = pval_reg;
        found_next = found_reg;
        if (finish)
        begin
            hi_next    = bad ? '0 : addr_flat[ilpp_pkg::ADDR_W-1:ilpp_pkg::HALF_W];
            lo_next    = bad ? '0 : addr_flat[ilpp_pkg::HALF_W-1:0];
            bad_next   = bad;
            pval_next  = found ? port_next : '0;
            found_next = found;
        end

        if (finish)
        begin
            ovalid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            ovalid_next = 1'b0;
        end
        else
        begin
            ovalid_next = ovalid_reg;
        end

        // URI done: back to the idle parse state for the next one
        if (finish)
        begin
            for (int k = 0; k < ilpp_pkg::GROUPS; k++)
            begin
                pre_next[k] = '0;
            end
            post_next    = '0;
            count_next   = '0;
            accum_next   = '0;
            digits_next  = '0;
            gap_pos_next = '0;
            gap_next     = 1'b0;
            phase_next   = ilpp_pkg::PH_WAIT;
            port_next    = '0;
            plen_next    = '0;
            pdone_next   = 1'b0;
            err_next     = 1'b0;
            colon_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ilpp_pkg::GROUPS; k++)
            begin
                pre_reg[k] <= '0;
            end
            post_reg    <= '0;
            count_reg   <= '0;
            accum_reg   <= '0;
            digits_reg  <= '0;
            gap_pos_reg <= '0;
            gap_reg     <= 1'b0;
            phase_reg   <= ilpp_pkg::PH_WAIT;
            port_reg    <= '0;
            plen_reg    <= '0;
            pdone_reg   <= 1'b0;
            err_reg     <= 1'b0;
            colon_reg   <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            pre_reg     <= pre_next;
            post_reg    <= post_next;
            count_reg   <= count_next;
            accum_reg   <= accum_next;
            digits_reg  <= digits_next;
            gap_pos_reg <= gap_pos_next;
            gap_reg     <= gap_next;
            phase_reg   <= phase_next;
            port_reg    <= port_next;
            plen_reg    <= plen_next;
            pdone_reg   <= pdone_next;
            err_reg     <= err_next;
            colon_reg   <= colon_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        bad_reg   <= bad_next;
        pval_reg  <= pval_next;
        found_reg <= found_next;
    end

endmodule

[rtl/ipv6_literal_and_port_parser.sv]
// ---------------------------------------------------------------------------
// ipv6_literal_and_port_parser
// Parses a bracketed IPv6 literal and decimal port from a URI character stream.
// ---------------------------------------------------------------------------
// Throughput: one character per cycle, sustained while out_stall does not hold back a last character.
// Path: a last character is written into the queue entry, then popped by the parser,
//   which loads the result register and sets out_valid; a held result blocks that pop.
// The result register frees the parser while a finished transaction waits on out_stall.
// Reset: asynchronous, clears parse state, queue and result valid; no clearing pass.
module ipv6_literal_and_port_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  char_code,
    input  logic                        last_char,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ilpp_pkg::HALF_W-1:0] addr_high,
    output logic [ilpp_pkg::HALF_W-1:0] addr_low,
    output logic                        addr_error,
    output logic [ilpp_pkg::PORT_W-1:0] port_value,
    output logic                        port_found
);

    ilpp_pkg::item_t in_item;
    ilpp_pkg::item_t head;
    logic            q_full;
    logic            q_avail;
    logic            q_pop;

    assign in_stall = q_full;

    ilpp_front u_front (
        .char_code (char_code),
        .last_char (last_char),
        .item      (in_item)
    );

    ilpp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_item (in_item),
        .full      (q_full),
        .pop       (q_pop),
        .avail     (q_avail),
        .head      (head)
    );

    ilpp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .avail      (q_avail),
        .head       (head),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .addr_high  (addr_high),
        .addr_low   (addr_low),
        .addr_error (addr_error),
        .port_value (port_value),
        .port_found (port_found)
    );

endmodule
